### sv/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types, result codes and sizing helpers for the tick timer table.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] KIND_EXPIRY = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    // one stored timer
    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] tag;
    } entry_t;

    // one result as produced by the sequencer, before the output register
    typedef struct packed {
        logic        strobe;
        logic [1:0]  kind;
        logic [63:0] tag;
        logic        resched;
        logic        last;
    } res_t;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int cnt_width(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

### sv/ttt_store.sv
// ----------------------------------------------------------------------------
// ttt_store
// Timer entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttt_store
    import ttt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDXW = idx_width(DEPTH)
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [IDXW-1:0] waddr,
    input  entry_t          wdata,
    input  logic [IDXW-1:0] raddr,
    output entry_t          rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ttt_seq.sv
// ----------------------------------------------------------------------------
// ttt_seq
// Sequencer for the timer table. Handles adds in the accept cycle; for a tick
// it scans the table newest first to report expiries, then scans oldest
// first to pack the survivors, then reports status. A single 64-bit compare
// serves every deadline check and the slice check.
// ----------------------------------------------------------------------------
module ttt_seq
    import ttt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDXW = idx_width(DEPTH),
    localparam int CNTW = cnt_width(DEPTH)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            cmd,
    input  logic [31:0]     delay_ticks,
    input  logic [63:0]     tag_in,
    input  logic [63:0]     slice_end,
    input  logic [63:0]     counter,
    output logic            busy,
    output logic            we,
    output logic [IDXW-1:0] waddr,
    output entry_t          wdata,
    output logic [IDXW-1:0] raddr,
    input  entry_t          rdata,
    output res_t            res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DOWN = 2'd1;
    localparam logic [1:0] S_UP   = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(DEPTH);

    logic [1:0]      state_reg, state_next;
    logic [IDXW-1:0] ptr_reg,   ptr_next;
    logic [CNTW-1:0] rem_reg,   rem_next;
    logic [CNTW-1:0] kept_reg,  kept_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            dvld_reg,  dvld_next;
    logic [63:0]     slice_reg, slice_next;

    logic [63:0]     cmp_b;
    logic            ge;

    // shared compare unit
    assign cmp_b = (state_reg == S_STAT) ? slice_reg : rdata.deadline;
    assign ge    = (counter >= cmp_b);

    assign busy  = (state_reg != S_IDLE);
    assign raddr = ptr_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        kept_next  = kept_reg;
        count_next = count_reg;
        slice_next = slice_reg;
        dvld_next  = 1'b0;
        we         = 1'b0;
        waddr      = count_reg[IDXW-1:0];
        wdata      = '{deadline: counter + {32'd0, delay_ticks}, tag: tag_in};
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd)
                    begin
                        res.strobe = 1'b1;
                        res.last   = 1'b1;
                        if (count_reg == DEPTH_CNT)
                        begin
                            res.kind = KIND_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + 1'b1;
                            res.kind   = KIND_ACK;
                        end
                    end
                    else
                    begin
                        slice_next = slice_end;
                        if (count_reg == '0)
                        begin
                            state_next = S_STAT;
                        end
                        else
                        begin
                            state_next = S_DOWN;
                            ptr_next   = IDXW'(count_reg - 1'b1);
                            rem_next   = count_reg;
                        end
                    end
                end
            end

            S_DOWN:
            begin
                if (rem_reg != '0)
                begin
                    dvld_next = 1'b1;
                    ptr_next  = ptr_reg - 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                if (dvld_reg && ge)
                begin
                    res.strobe = 1'b1;
                    res.kind   = KIND_EXPIRY;
                    res.tag    = rdata.tag;
                end
                if (rem_reg == '0 && !dvld_reg)
                begin
                    state_next = S_UP;
                    ptr_next   = '0;
                    rem_next   = count_reg;
                    kept_next  = '0;
                end
            end

            S_UP:
            begin
                if (rem_reg != '0)
                begin
                    dvld_next = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                // pack survivors toward slot 0, keeping their order
                if (dvld_reg && !ge)
                begin
                    we        = 1'b1;
                    waddr     = kept_reg[IDXW-1:0];
                    wdata     = rdata;
                    kept_next = kept_reg + 1'b1;
                end
                if (rem_reg == '0 && !dvld_reg)
                begin
                    count_next = kept_reg;
                    state_next = S_STAT;
                end
            end

            S_STAT:
            begin
                res.strobe  = 1'b1;
                res.kind    = KIND_STATUS;
                res.resched = ge;
                res.last    = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            count_reg <= '0;
            dvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            dvld_reg  <= dvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        kept_reg  <= kept_next;
        slice_reg <= slice_next;
    end

endmodule

### sv/tick_timer_table.sv
// ----------------------------------------------------------------------------
// tick_timer_table
// 64-bit tick counter with a table of one-shot timers.
// ----------------------------------------------------------------------------
// An add transaction (cmd = 1) is answered in the cycle after it is taken by one
// result, ack or full, and busy stays low, so another transaction may follow
// right away. While a tick transaction (cmd = 0) runs, busy stays high: the
// table memory is read once per timer newest first to report expiries, then
// once per timer oldest first to pack the survivors, all through one shared
// 64-bit compare. Results appear on the result ports for one cycle each, marked
// by valid, and must be taken when shown: the block never holds them back. Last
// marks the final result of a transaction; busy is low in that same cycle.
module tick_timer_table
    import ttt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] delay_ticks,
    input  logic [63:0] tag_in,
    input  logic [63:0] slice_end,
    output logic        valid,
    output logic [1:0]  kind,
    output logic [63:0] tag_out,
    output logic [63:0] tick_count,
    output logic        resched,
    output logic        last
);

    localparam int IDXW = idx_width(DEPTH);

    logic [63:0]     counter_reg, counter_next;
    logic            valid_reg;
    logic [1:0]      kind_reg;
    logic [63:0]     tag_reg;
    logic            resched_reg;
    logic            last_reg;

    logic            seq_busy;
    logic            we;
    logic [IDXW-1:0] waddr;
    logic [IDXW-1:0] raddr;
    entry_t          wdata;
    entry_t          rdata;
    res_t            res;

    ttt_seq #(.DEPTH(DEPTH)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .delay_ticks (delay_ticks),
        .tag_in      (tag_in),
        .slice_end   (slice_end),
        .counter     (counter_reg),
        .busy        (seq_busy),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr       (raddr),
        .rdata       (rdata),
        .res         (res)
    );

    ttt_store #(.DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // advance the counter when a tick transaction is taken
    always_comb
    begin
        counter_next = counter_reg;
        if (start && !seq_busy && !cmd)
        begin
            counter_next = counter_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            valid_reg   <= res.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= res.kind;
        tag_reg     <= res.tag;
        resched_reg <= res.resched;
        last_reg    <= res.last;
    end

    assign busy       = seq_busy;
    assign valid      = valid_reg;
    assign kind       = kind_reg;
    assign tag_out    = tag_reg;
    assign tick_count = counter_reg;
    assign resched    = resched_reg;
    assign last       = last_reg;

endmodule

### sv/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks for the tick timer table, bound to the top level.
// ----------------------------------------------------------------------------
module ttt_checker
    import ttt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cmd,
    input logic        valid,
    input logic [1:0]  kind,
    input logic [63:0] tag_out,
    input logic [63:0] tick_count,
    input logic        resched,
    input logic        last
);

    // an add is answered in the next cycle by a single ack or full
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd) |=> (valid && last && (kind == KIND_ACK || kind == KIND_FULL)))
        else $error("add transaction not answered by one ack or full");

    // a tick advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cmd) |=> (tick_count == $past(tick_count) + 64'd1))
        else $error("tick did not advance the counter by one");

    // expiries are never final and carry no reschedule flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == KIND_EXPIRY) |-> (!last && !resched))
        else $error("expiry result marked last or resched");

    // non-expiry results are final and carry a zero tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind != KIND_EXPIRY) |-> (last && tag_out == 64'd0))
        else $error("non-expiry result not last or with nonzero tag");

    // the block is ready again when the final result shows
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |-> !busy)
        else $error("busy still high at final result");

endmodule

bind tick_timer_table ttt_checker u_ttt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .valid      (valid),
    .kind       (kind),
    .tag_out    (tag_out),
    .tick_count (tick_count),
    .resched    (resched),
    .last       (last)
);

### tb/tick_timer_table_test.sv
// ----------------------------------------------------------------------------
// tick_timer_table_test
// Self-checking bench for the tick timer table. A directed opening covers the
// empty and full table, zero and maximum delays, same-tick expiries and the
// reschedule flag on both sides of the slice end. Random add/tick traffic
// follows. Every result is compared against an in-bench timer table.
// ----------------------------------------------------------------------------
module tick_timer_table_test;
    import ttt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 24;

    typedef struct {
        logic        cmd;
        logic [31:0] delay;
        logic [63:0] tag;
        logic [63:0] slice;
        bit          drain_first;
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] tag;
        logic [63:0] ticks;
        logic        resched;
        logic        last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        cmd = 1'b0;
    logic [31:0] delay_ticks = '0;
    logic [63:0] tag_in = '0;
    logic [63:0] slice_end = '0;
    logic        busy;
    logic        valid;
    logic [1:0]  kind;
    logic [63:0] tag_out;
    logic [63:0] tick_count;
    logic        resched;
    logic        last;

    timer_cmd_t    cmd_backlog[$];
    timer_result_t due_results[$];

    // timer table as the block should hold it; slot 0 is the oldest timer
    logic [63:0] sw_ticks = '0;
    logic [63:0] sw_deadline[DEPTH];
    logic [63:0] sw_tag[DEPTH];
    int          sw_count = 0;

    int unsigned items_taken = 0;
    int unsigned total_items = 0;
    int unsigned cycle_count = 0;
    int          errors = 0;
    logic [63:0] gen_ticks = '0;

    tick_timer_table #(.DEPTH(DEPTH)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .delay_ticks (delay_ticks),
        .tag_in      (tag_in),
        .slice_end   (slice_end),
        .valid       (valid),
        .kind        (kind),
        .tag_out     (tag_out),
        .tick_count  (tick_count),
        .resched     (resched),
        .last        (last)
    );

    always #2 clk = ~clk;

    // Apply one transaction to the table and queue the results it must give.
    task automatic apply_timer_cmd(input logic c, input logic [31:0] d,
                                   input logic [63:0] t, input logic [63:0] s);
        int            kept;
        timer_result_t r;
        kept = 0;
        if (c)
        begin
            if (sw_count >= DEPTH)
            begin
                r = '{KIND_FULL, 64'd0, sw_ticks, 1'b0, 1'b1};
            end
            else
            begin
                sw_deadline[sw_count] = sw_ticks + {32'd0, d};
                sw_tag[sw_count] = t;
                sw_count++;
                r = '{KIND_ACK, 64'd0, sw_ticks, 1'b0, 1'b1};
            end
            due_results.push_back(r);
        end
        else
        begin
            sw_ticks = sw_ticks + 64'd1;
            // report newest first
            for (int i = sw_count - 1; i >= 0; i--)
            begin
                if (sw_ticks >= sw_deadline[i])
                begin
                    r = '{KIND_EXPIRY, sw_tag[i], sw_ticks, 1'b0, 1'b0};
                    due_results.push_back(r);
                end
            end
            // pack survivors, keep their order
            for (int i = 0; i < sw_count; i++)
            begin
                if (sw_ticks < sw_deadline[i])
                begin
                    sw_deadline[kept] = sw_deadline[i];
                    sw_tag[kept] = sw_tag[i];
                    kept++;
                end
            end
            sw_count = kept;
            r = '{KIND_STATUS, 64'd0, sw_ticks, (sw_ticks >= s), 1'b1};
            due_results.push_back(r);
        end
    endtask

    task automatic queue_add(input logic [31:0] d, input logic [63:0] t, input bit hold);
        timer_cmd_t c;
        c = '{1'b1, d, t, {$urandom, $urandom}, hold};
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_tick(input logic [63:0] s, input bit hold);
        timer_cmd_t c;
        c = '{1'b0, $urandom, {$urandom, $urandom}, s, hold};
        cmd_backlog.push_back(c);
        gen_ticks = gen_ticks + 64'd1;
    endtask

    // Driver: present the next transaction once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        timer_cmd_t nxt;
        bit         quiet;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            quiet = (items_taken >= 200 && items_taken < 300);
            if (cmd_backlog.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (cmd_backlog[0].drain_first && (start || due_results.size() != 0))
            begin
                // hold until every outstanding result has come back
                start <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < 15)
            begin
                start <= 1'b0;
            end
            else
            begin
                nxt = cmd_backlog.pop_front();
                start       <= 1'b1;
                cmd         <= nxt.cmd;
                delay_ticks <= nxt.delay;
                tag_in      <= nxt.tag;
                slice_end   <= nxt.slice;
            end
        end
    end

    // Monitor: check each result, then model any transaction taken at this edge.
    always @(posedge clk)
    begin
        timer_result_t got;
        timer_result_t want;
        if (rst_n)
        begin
            if (valid === 1'b1)
            begin
                got = '{kind, tag_out, tick_count, resched, last};
                if (due_results.size() == 0)
                begin
                    $display({"%0t: unexpected result kind=%0d tag=%h ticks=%0d",
                              " resched=%b last=%b"},
                             $time, kind, tag_out, tick_count, resched, last);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch expected kind=%0d tag=%h",
                                  " ticks=%0d resched=%b last=%b"},
                                 $time, want.kind, want.tag, want.ticks,
                                 want.resched, want.last);
                        $display({"%0t:          actual   kind=%0d tag=%h",
                                  " ticks=%0d resched=%b last=%b"},
                                 $time, kind, tag_out, tick_count, resched, last);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_timer_cmd(cmd, delay_ticks, tag_in, slice_end);
                items_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tick_timer_table regression: fail");
            $finish;
        end
    end

    initial
    begin
        int          add_pct;
        int          big_left;
        int          r;
        logic [31:0] d;
        logic [63:0] s;

        big_left = 2;
        add_pct = 50;

        // directed opening
        queue_tick(64'd0, 1'b0);
        queue_tick('1, 1'b0);
        queue_add(32'd0, '1, 1'b0);
        queue_add('1, 64'd0, 1'b0);
        queue_add(32'd1, 64'h5555_5555_5555_5555, 1'b0);
        queue_add(32'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_tick(64'd4, 1'b1);
        queue_tick(64'd4, 1'b0);
        // fill the table behind the permanent timer, then overflow it
        for (int i = 0; i < DEPTH; i++)
            queue_add($urandom_range(1, 2), {$urandom, $urandom}, 1'b0);
        queue_tick(gen_ticks + 64'd1, 1'b0);

        // random traffic
        for (int n = 0; n < 385; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(2))
                    0: add_pct = 30;
                    1: add_pct = 50;
                    default: add_pct = 75;
                endcase
            end
            if ($urandom_range(99) < add_pct)
            begin
                r = $urandom_range(99);
                if (r < 80)
                    d = $urandom_range(0, 6);
                else if (r < 98 || big_left == 0)
                    d = $urandom_range(0, 40);
                else
                begin
                    d = $urandom;
                    big_left--;
                end
                queue_add(d, {$urandom, $urandom}, (n % 97 == 96));
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                    s = gen_ticks + 64'd1 - 64'd2 + 64'($urandom_range(0, 4));
                else if (r < 70)
                    s = {$urandom, $urandom};
                else
                    s = 64'($urandom_range(0, 300));
                queue_tick(s, (n % 97 == 96));
            end
        end
        total_items = cmd_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tick_timer_table regression: pass");
        else
            $display("tick_timer_table regression: fail");
        $finish;
    end

endmodule
